FILE: hdl/triangle_circumcentre_top_defines.svh
// assertion macros for the circumcentre block
`ifndef TRIANGLE_CIRCUMCENTRE_TOP_DEFINES_SVH
`define TRIANGLE_CIRCUMCENTRE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// checked outside reset
`define TCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define TCC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/tcc_pkg.sv
package tcc_pkg;

  // coordinate and intermediate widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned DetW   = ProdW + 1;
  localparam int unsigned DenW   = DetW + 1;
  localparam int unsigned SqW    = ProdW;
  localparam int unsigned HalfW  = SqW / 2;
  localparam int unsigned PartW  = DiffW + HalfW + 1;
  localparam int unsigned TermW  = DiffW + SqW + 1;
  localparam int unsigned NumW   = TermW + 1;
  localparam int unsigned NmW    = NumW + 2;
  localparam int unsigned D2W    = DenW + 1;
  localparam int unsigned QuotW  = CoordW + 1;
  localparam int unsigned RemW   = ((NmW > D2W + QuotW) ? NmW : (D2W + QuotW)) + 1;

  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
  } tri_t;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic                     neg_x;
    logic                     neg_y;
    logic                     big_x;
    logic                     big_y;
    logic                     degen;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [RemW-1:0]   rem_x;
    logic [RemW-1:0]   rem_y;
    logic [D2W-1:0]    d2;
  } div_in_t;

  typedef struct packed {
    side_t             side;
    logic [QuotW-1:0]  q_x;
    logic [QuotW-1:0]  q_y;
  } div_out_t;

endpackage

FILE: hdl/tcc_if.sv
// triangle input channel
interface tcc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [tcc_pkg::CoordW-1:0]        vertex_a_x;
  logic signed [tcc_pkg::CoordW-1:0]        vertex_a_y;
  logic signed [tcc_pkg::CoordW-1:0]        vertex_b_x;
  logic signed [tcc_pkg::CoordW-1:0]        vertex_b_y;
  logic signed [tcc_pkg::CoordW-1:0]        vertex_c_x;
  logic signed [tcc_pkg::CoordW-1:0]        vertex_c_y;

  modport source (output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, input ready);
  modport sink   (input valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, output ready);
endinterface

// circumcentre result channel
interface tcc_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [tcc_pkg::CoordW-1:0]        centre_x;
  logic signed [tcc_pkg::CoordW-1:0]        centre_y;
  logic                                     degenerate;
  logic                                     overflow;

  modport source (output valid, centre_x, centre_y, degenerate, overflow, input ready);
  modport sink   (input valid, centre_x, centre_y, degenerate, overflow, output ready);
endinterface

FILE: hdl/triangle_circumcentre_top.sv
// Circumcentre of a triangle in signed Q16.16: takes one triangle per clock while no
// result is held at the output, and returns one result per triangle, in order,
// through eight arithmetic stages, 33 restoring-division stages giving one quotient
// bit each, and the output register. The whole pipeline advances as one: while a
// result waits at the output, every stage holds, and input ready falls with it.
// Collinear points give a zero centre with the degenerate flag; a centre beyond
// the coordinate range is clamped to the nearer bound and raises overflow.
`include "triangle_circumcentre_top_defines.svh"

module triangle_circumcentre_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcc_in_if.sink      in_if,
  tcc_out_if.source   out_if
);

  logic              en;
  logic              front_vld, div_vld, out_vld;
  tcc_pkg::tri_t     tri_in;
  tcc_pkg::div_in_t  div_in;
  tcc_pkg::div_out_t div_out;
  logic              out_zero, x_at_bound, y_at_bound;

  // global advance: output register free or its beat taken
  assign en          = !out_vld || out_if.ready;
  assign in_if.ready = en;

  assign tri_in.a_x = in_if.vertex_a_x;
  assign tri_in.a_y = in_if.vertex_a_y;
  assign tri_in.b_x = in_if.vertex_b_x;
  assign tri_in.b_y = in_if.vertex_b_y;
  assign tri_in.c_x = in_if.vertex_c_x;
  assign tri_in.c_y = in_if.vertex_c_y;

  tcc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_if.valid),
    .tri_i   (tri_in),
    .valid_o (front_vld),
    .div_o   (div_in)
  );

  tcc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_vld),
    .div_i   (div_in),
    .valid_o (div_vld),
    .div_o   (div_out)
  );

  tcc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (div_vld),
    .res_i        (div_out),
    .valid_o      (out_vld),
    .centre_x_o   (out_if.centre_x),
    .centre_y_o   (out_if.centre_y),
    .degenerate_o (out_if.degenerate),
    .overflow_o   (out_if.overflow)
  );

  assign out_if.valid = out_vld;

  // result shapes used by the checks
  assign out_zero   = (out_if.centre_x == '0) && (out_if.centre_y == '0);
  assign x_at_bound = (out_if.centre_x == tcc_pkg::CoordMax) ||
                      (out_if.centre_x == tcc_pkg::CoordMin);
  assign y_at_bound = (out_if.centre_y == tcc_pkg::CoordMax) ||
                      (out_if.centre_y == tcc_pkg::CoordMin);

  // checks
  `TCC_ASSERT_NR(a_rst_empty, clk_i, !rst_ni |=> !out_if.valid, "output valid after reset")
  `TCC_ASSERT(a_ready_free, clk_i, rst_ni, !out_if.valid |-> in_if.ready, "stalled while empty")
  `TCC_ASSERT(a_degen_zero, clk_i, rst_ni, out_if.valid && out_if.degenerate |-> out_zero && !out_if.overflow, "degenerate result not zero")
  `TCC_ASSERT(a_ovf_bound, clk_i, rst_ni, out_if.valid && out_if.overflow |-> x_at_bound || y_at_bound, "overflow off bound")

endmodule

FILE: hdl/tcc_front.sv
// eight stages: translate, products, determinant and squares,
// split products, term sums, numerators, magnitudes, range check
module tcc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  tcc_pkg::tri_t    tri_i,
  output logic             valid_o,
  output tcc_pkg::div_in_t div_o
);

  localparam int unsigned CoordW = tcc_pkg::CoordW;
  localparam int unsigned DiffW  = tcc_pkg::DiffW;
  localparam int unsigned ProdW  = tcc_pkg::ProdW;
  localparam int unsigned DetW   = tcc_pkg::DetW;
  localparam int unsigned DenW   = tcc_pkg::DenW;
  localparam int unsigned SqW    = tcc_pkg::SqW;
  localparam int unsigned HalfW  = tcc_pkg::HalfW;
  localparam int unsigned PartW  = tcc_pkg::PartW;
  localparam int unsigned TermW  = tcc_pkg::TermW;
  localparam int unsigned NumW   = tcc_pkg::NumW;
  localparam int unsigned NmW    = tcc_pkg::NmW;
  localparam int unsigned D2W    = tcc_pkg::D2W;
  localparam int unsigned QuotW  = tcc_pkg::QuotW;
  localparam int unsigned RemW   = tcc_pkg::RemW;
  localparam int unsigned Stages = 8;

  logic [Stages-1:0] vld_q;

  // origin vertex carried down the stages
  logic signed [CoordW-1:0] cx_q [Stages-1];
  logic signed [CoordW-1:0] cy_q [Stages-1];

  logic signed [DiffW-1:0] ax1_q, ay1_q, bx1_q, by1_q;
  logic signed [DiffW-1:0] ax2_q, ay2_q, bx2_q, by2_q;
  logic signed [DiffW-1:0] ax3_q, ay3_q, bx3_q, by3_q;
  logic signed [ProdW-1:0] axby2_q, aybx2_q, axax2_q, ayay2_q, bxbx2_q, byby2_q;
  logic signed [DetW-1:0]  det3_q, det4_q, det5_q;
  logic        [SqW-1:0]   sqa3_q, sqb3_q;
  logic signed [PartW-1:0] aysqb_lo4_q, aysqb_hi4_q, bysqa_lo4_q, bysqa_hi4_q;
  logic signed [PartW-1:0] axsqb_lo4_q, axsqb_hi4_q, bxsqa_lo4_q, bxsqa_hi4_q;
  logic signed [TermW-1:0] aysqb5_q, bysqa5_q, axsqb5_q, bxsqa5_q;
  logic signed [NumW-1:0]  numx6_q, numy6_q;
  logic signed [DenW-1:0]  den6_q;
  logic                    degen6_q, degen7_q;
  logic        [NmW-1:0]   nx7_q, ny7_q;
  logic        [D2W-1:0]   d27_q;
  logic                    negx7_q, negy7_q;
  tcc_pkg::div_in_t        div_q;

  // unsigned halves of the squared lengths
  logic signed [HalfW:0]   sqa_lo, sqa_hi, sqb_lo, sqb_hi;
  assign sqa_lo = {1'b0, sqa3_q[HalfW-1:0]};
  assign sqa_hi = {1'b0, sqa3_q[SqW-1:HalfW]};
  assign sqb_lo = {1'b0, sqb3_q[HalfW-1:0]};
  assign sqb_hi = {1'b0, sqb3_q[SqW-1:HalfW]};

  // magnitudes for the rounded division
  logic [NumW-1:0] absnx, absny;
  logic [DenW-1:0] absd;
  assign absnx = numx6_q[NumW-1] ? NumW'(-numx6_q) : NumW'(numx6_q);
  assign absny = numy6_q[NumW-1] ? NumW'(-numy6_q) : NumW'(numy6_q);
  assign absd  = den6_q[DenW-1] ? DenW'(-den6_q) : DenW'(den6_q);

  // quotient too big for the coordinate range
  logic [RemW-1:0] dlim;
  assign dlim = RemW'(d27_q) << QuotW;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-2:0], valid_i};
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= tri_i.c_x;
      cy_q[0] <= tri_i.c_y;
      for (int k = 1; k < Stages - 1; k++) begin
        cx_q[k] <= cx_q[k-1];
        cy_q[k] <= cy_q[k-1];
      end

      ax1_q <= DiffW'(tri_i.a_x) - DiffW'(tri_i.c_x);
      ay1_q <= DiffW'(tri_i.a_y) - DiffW'(tri_i.c_y);
      bx1_q <= DiffW'(tri_i.b_x) - DiffW'(tri_i.c_x);
      by1_q <= DiffW'(tri_i.b_y) - DiffW'(tri_i.c_y);

      axby2_q <= ax1_q * by1_q;
      aybx2_q <= ay1_q * bx1_q;
      axax2_q <= ax1_q * ax1_q;
      ayay2_q <= ay1_q * ay1_q;
      bxbx2_q <= bx1_q * bx1_q;
      byby2_q <= by1_q * by1_q;
      ax2_q <= ax1_q;
      ay2_q <= ay1_q;
      bx2_q <= bx1_q;
      by2_q <= by1_q;

      det3_q <= DetW'(axby2_q) - DetW'(aybx2_q);
      sqa3_q <= $unsigned(axax2_q) + $unsigned(ayay2_q);
      sqb3_q <= $unsigned(bxbx2_q) + $unsigned(byby2_q);
      ax3_q <= ax2_q;
      ay3_q <= ay2_q;
      bx3_q <= bx2_q;
      by3_q <= by2_q;

      aysqb_lo4_q <= ay3_q * sqb_lo;
      aysqb_hi4_q <= ay3_q * sqb_hi;
      bysqa_lo4_q <= by3_q * sqa_lo;
      bysqa_hi4_q <= by3_q * sqa_hi;
      axsqb_lo4_q <= ax3_q * sqb_lo;
      axsqb_hi4_q <= ax3_q * sqb_hi;
      bxsqa_lo4_q <= bx3_q * sqa_lo;
      bxsqa_hi4_q <= bx3_q * sqa_hi;
      det4_q <= det3_q;

      aysqb5_q <= (TermW'(aysqb_hi4_q) <<< HalfW) + TermW'(aysqb_lo4_q);
      bysqa5_q <= (TermW'(bysqa_hi4_q) <<< HalfW) + TermW'(bysqa_lo4_q);
      axsqb5_q <= (TermW'(axsqb_hi4_q) <<< HalfW) + TermW'(axsqb_lo4_q);
      bxsqa5_q <= (TermW'(bxsqa_hi4_q) <<< HalfW) + TermW'(bxsqa_lo4_q);
      det5_q <= det4_q;

      numx6_q  <= NumW'(aysqb5_q) - NumW'(bysqa5_q);
      numy6_q  <= NumW'(axsqb5_q) - NumW'(bxsqa5_q);
      den6_q   <= DenW'(det5_q) <<< 1;
      degen6_q <= (det5_q == '0);

      nx7_q    <= (NmW'(absnx) << 1) + NmW'(absd);
      ny7_q    <= (NmW'(absny) << 1) + NmW'(absd);
      d27_q    <= D2W'(absd) << 1;
      negx7_q  <= numx6_q[NumW-1] ^ den6_q[DenW-1];
      negy7_q  <= numy6_q[NumW-1] ^ den6_q[DenW-1];
      degen7_q <= degen6_q;

      div_q.side.cx    <= cx_q[Stages-2];
      div_q.side.cy    <= cy_q[Stages-2];
      div_q.side.neg_x <= negx7_q;
      div_q.side.neg_y <= negy7_q;
      div_q.side.big_x <= (RemW'(nx7_q) >= dlim);
      div_q.side.big_y <= (RemW'(ny7_q) >= dlim);
      div_q.side.degen <= degen7_q;
      div_q.rem_x      <= RemW'(nx7_q);
      div_q.rem_y      <= RemW'(ny7_q);
      div_q.d2         <= d27_q;
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign div_o   = div_q;

endmodule

FILE: hdl/tcc_div.sv
// restoring division, one quotient bit per stage, x and y lanes side by side
module tcc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  tcc_pkg::div_in_t  div_i,
  output logic              valid_o,
  output tcc_pkg::div_out_t div_o
);

  localparam int unsigned QuotW = tcc_pkg::QuotW;
  localparam int unsigned RemW  = tcc_pkg::RemW;
  localparam int unsigned D2W   = tcc_pkg::D2W;

  logic [QuotW-1:0]    vld_q;
  logic [RemW-1:0]     rx_q [QuotW];
  logic [RemW-1:0]     ry_q [QuotW];
  logic [QuotW-1:0]    qx_q [QuotW];
  logic [QuotW-1:0]    qy_q [QuotW];
  logic [D2W-1:0]      d2_q [QuotW];
  tcc_pkg::side_t      side_q [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    localparam int unsigned Sh = QuotW - 1 - k;

    logic [RemW-1:0]  rx_in, ry_in, dsh;
    logic [QuotW-1:0] qx_in, qy_in;
    logic [D2W-1:0]   d2_in;
    tcc_pkg::side_t   side_in;
    logic             vld_in, gex, gey;

    if (k == 0) begin : g_first
      assign rx_in   = div_i.rem_x;
      assign ry_in   = div_i.rem_y;
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign d2_in   = div_i.d2;
      assign side_in = div_i.side;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rx_in   = rx_q[k-1];
      assign ry_in   = ry_q[k-1];
      assign qx_in   = qx_q[k-1];
      assign qy_in   = qy_q[k-1];
      assign d2_in   = d2_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // trial subtract of the shifted divisor
    assign dsh = RemW'(d2_in) << Sh;
    assign gex = (rx_in >= dsh);
    assign gey = (ry_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[k]   <= gex ? rx_in - dsh : rx_in;
        ry_q[k]   <= gey ? ry_in - dsh : ry_in;
        qx_q[k]   <= {qx_in[QuotW-2:0], gex};
        qy_q[k]   <= {qy_in[QuotW-2:0], gey};
        d2_q[k]   <= d2_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o    = vld_q[QuotW-1];
  assign div_o.side = side_q[QuotW-1];
  assign div_o.q_x  = qx_q[QuotW-1];
  assign div_o.q_y  = qy_q[QuotW-1];

endmodule

FILE: hdl/tcc_back.sv
// sign, offset from the origin vertex, saturation and the output register
module tcc_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  tcc_pkg::div_out_t                  res_i,
  output logic                               valid_o,
  output logic signed [tcc_pkg::CoordW-1:0]  centre_x_o,
  output logic signed [tcc_pkg::CoordW-1:0]  centre_y_o,
  output logic                               degenerate_o,
  output logic                               overflow_o
);

  localparam int unsigned CoordW = tcc_pkg::CoordW;
  localparam int unsigned QuotW  = tcc_pkg::QuotW;
  localparam int unsigned MagW   = QuotW + 1;
  localparam int unsigned SumW   = MagW + 2;

  // clamp to the coordinate range, flag in the top bit
  function automatic logic [CoordW:0] sat(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] lo, hi;
    lo = SumW'(tcc_pkg::CoordMin);
    hi = SumW'(tcc_pkg::CoordMax);
    if (v < lo) begin
      return {1'b1, tcc_pkg::CoordMin};
    end else if (v > hi) begin
      return {1'b1, tcc_pkg::CoordMax};
    end
    return {1'b0, v[CoordW-1:0]};
  endfunction

  logic [MagW-1:0]        magx, magy;
  logic signed [MagW:0]   magx_s, magy_s, sqx, sqy;
  logic signed [SumW-1:0] ccx, ccy;
  logic [CoordW:0]        satx, saty;

  // oversized quotients stand in as one past the range
  assign magx   = res_i.side.big_x ? (MagW'(1) << QuotW) : MagW'(res_i.q_x);
  assign magy   = res_i.side.big_y ? (MagW'(1) << QuotW) : MagW'(res_i.q_y);
  assign magx_s = {1'b0, magx};
  assign magy_s = {1'b0, magy};
  assign sqx    = res_i.side.neg_x ? -magx_s : magx_s;
  assign sqy    = res_i.side.neg_y ? -magy_s : magy_s;
  assign ccx    = SumW'(res_i.side.cx) - SumW'(sqx);
  assign ccy    = SumW'(res_i.side.cy) + SumW'(sqy);
  assign satx   = sat(ccx);
  assign saty   = sat(ccy);

  logic vld_q;
  logic signed [CoordW-1:0] cx_q, cy_q;
  logic degen_q, ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  // collinear points give a zero centre
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (res_i.side.degen) begin
        cx_q    <= '0;
        cy_q    <= '0;
        degen_q <= 1'b1;
        ovf_q   <= 1'b0;
      end else begin
        cx_q    <= satx[CoordW-1:0];
        cy_q    <= saty[CoordW-1:0];
        degen_q <= 1'b0;
        ovf_q   <= satx[CoordW] | saty[CoordW];
      end
    end
  end

  assign valid_o      = vld_q;
  assign centre_x_o   = cx_q;
  assign centre_y_o   = cy_q;
  assign degenerate_o = degen_q;
  assign overflow_o   = ovf_q;

endmodule

FILE: dv/triangle_circumcentre_top_tb.sv
module triangle_circumcentre_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 500;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 60;

  typedef logic signed [191:0] exact_t;

  typedef struct packed {
    logic signed [tcc_pkg::CoordW-1:0] x;
    logic signed [tcc_pkg::CoordW-1:0] y;
    logic                              degen;
    logic                              ovf;
  } centre_t;

  // exact circumcentre with rounding and clamping
  function automatic exact_t round_quotient(exact_t num, exact_t den);
    exact_t an, ad, q;
    logic   neg;
    neg = (num < 0) != (den < 0);
    an  = (num < 0) ? -num : num;
    ad  = (den < 0) ? -den : den;
    q   = (2 * an + ad) / (2 * ad);
    return neg ? -q : q;
  endfunction

  function automatic logic signed [tcc_pkg::CoordW-1:0] clamp_coord(exact_t v,
                                                                   inout logic ovf);
    exact_t lo, hi;
    lo = -(exact_t'(1) <<< (tcc_pkg::CoordW - 1));
    hi = (exact_t'(1) <<< (tcc_pkg::CoordW - 1)) - 1;
    if (v < lo) begin
      ovf = 1'b1;
      return tcc_pkg::CoordMin;
    end
    if (v > hi) begin
      ovf = 1'b1;
      return tcc_pkg::CoordMax;
    end
    return v[tcc_pkg::CoordW-1:0];
  endfunction

  function automatic centre_t circumcentre_of(tcc_pkg::tri_t t);
    exact_t ax, ay, bx, by, det, sqa, sqb, nx, ny;
    centre_t r;
    logic ovf;
    ax  = exact_t'(t.a_x) - exact_t'(t.c_x);
    ay  = exact_t'(t.a_y) - exact_t'(t.c_y);
    bx  = exact_t'(t.b_x) - exact_t'(t.c_x);
    by  = exact_t'(t.b_y) - exact_t'(t.c_y);
    det = ax * by - ay * bx;
    if (det == 0) begin
      r = '{x: '0, y: '0, degen: 1'b1, ovf: 1'b0};
      return r;
    end
    sqa = ax * ax + ay * ay;
    sqb = bx * bx + by * by;
    nx  = ay * sqb - sqa * by;
    ny  = ax * sqb - sqa * bx;
    ovf = 1'b0;
    r.x = clamp_coord(exact_t'(t.c_x) - round_quotient(nx, 2 * det), ovf);
    r.y = clamp_coord(exact_t'(t.c_y) + round_quotient(ny, 2 * det), ovf);
    r.degen = 1'b0;
    r.ovf   = ovf;
    return r;
  endfunction

  // queue of predicted centres, oldest first
  class centre_scoreboard;
    centre_t pending[$];
    int      errors = 0;

    function void note_triangle(tcc_pkg::tri_t t);
      pending.push_back(circumcentre_of(t));
    endfunction

    function void check_result(centre_t got);
      centre_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d degen=%0b ovf=%0b",
                 $time, got.x, got.y, got.degen, got.ovf);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: centre_x expected %0d actual %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: centre_y expected %0d actual %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.degen !== want.degen) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, want.degen, got.degen);
        errors++;
      end
      if (got.ovf !== want.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tcc_in_if  tri_ch ();
  tcc_out_if ctr_ch ();

  triangle_circumcentre_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (tri_ch.sink),
    .out_if (ctr_ch.source)
  );

  centre_scoreboard sb = new();
  int unsigned send_idle_pct = 34;
  int unsigned recv_stall_pct = 57;
  int unsigned quiet_cycles = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // accepted triangle beats go to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && tri_ch.valid && tri_ch.ready) begin
      sb.note_triangle('{a_x: tri_ch.vertex_a_x, a_y: tri_ch.vertex_a_y,
                         b_x: tri_ch.vertex_b_x, b_y: tri_ch.vertex_b_y,
                         c_x: tri_ch.vertex_c_x, c_y: tri_ch.vertex_c_y});
    end
  end

  // result side: check accepted beats, stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      ctr_ch.ready <= 1'b0;
    end else begin
      if (ctr_ch.valid && ctr_ch.ready) begin
        sb.check_result('{x: ctr_ch.centre_x, y: ctr_ch.centre_y,
                          degen: ctr_ch.degenerate, ovf: ctr_ch.overflow});
      end
      ctr_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((tri_ch.valid && tri_ch.ready) || (ctr_ch.valid && ctr_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_triangle(tcc_pkg::tri_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      tri_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    tri_ch.valid      <= 1'b1;
    tri_ch.vertex_a_x <= t.a_x;
    tri_ch.vertex_a_y <= t.a_y;
    tri_ch.vertex_b_x <= t.b_x;
    tri_ch.vertex_b_y <= t.b_y;
    tri_ch.vertex_c_x <= t.c_x;
    tri_ch.vertex_c_y <= t.c_y;
    do @(posedge clk_i); while (!tri_ch.ready);
  endtask

  function automatic logic signed [tcc_pkg::CoordW-1:0] rand_coord(int unsigned span_bits);
    if (span_bits >= tcc_pkg::CoordW) return $urandom;
    return $signed($urandom & ((32'd1 << span_bits) - 1)) - (32'sd1 <<< (span_bits - 1));
  endfunction

  function automatic tcc_pkg::tri_t rand_triangle();
    tcc_pkg::tri_t t;
    int unsigned span;
    int k;
    case ($urandom_range(9))
      0, 1:    span = tcc_pkg::CoordW;
      2:       span = $urandom_range(2, 6);
      default: span = $urandom_range(8, 28);
    endcase
    t.a_x = rand_coord(span);
    t.a_y = rand_coord(span);
    t.b_x = rand_coord(span);
    t.b_y = rand_coord(span);
    t.c_x = rand_coord(span);
    t.c_y = rand_coord(span);
    // collinear sets, repeated points and shared x coordinates now and then
    case ($urandom_range(11))
      0: begin
        k = $urandom_range(0, 6) - 3;
        t.b_x = t.c_x + k * (t.a_x - t.c_x);
        t.b_y = t.c_y + k * (t.a_y - t.c_y);
      end
      1: t.b_x = t.a_x;
      2: begin
        t.a_x = t.c_x;
        t.a_y = t.c_y;
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic run_directed();
    tcc_pkg::tri_t dir[$];
    dir.push_back('{a_x: 0, a_y: 0, b_x: 0, b_y: 0, c_x: 0, c_y: 0});
    dir.push_back('{a_x: 32'sh10000, a_y: 0, b_x: 0, b_y: 32'sh10000, c_x: 0, c_y: 0});
    dir.push_back('{a_x: 0, a_y: 0, b_x: 32'sh20000, b_y: 0, c_x: 32'sh10000, c_y: 32'sh10000});
    dir.push_back('{a_x: 1, a_y: 1, b_x: 2, b_y: 2, c_x: 3, c_y: 3});
    dir.push_back('{a_x: 5, a_y: 7, b_x: 5, b_y: 7, c_x: -9, c_y: 4});
    dir.push_back('{a_x: tcc_pkg::CoordMax, a_y: tcc_pkg::CoordMax,
                    b_x: tcc_pkg::CoordMin, b_y: tcc_pkg::CoordMin, c_x: 0, c_y: 0});
    dir.push_back('{a_x: tcc_pkg::CoordMax, a_y: tcc_pkg::CoordMin,
                    b_x: tcc_pkg::CoordMin, b_y: tcc_pkg::CoordMax,
                    c_x: tcc_pkg::CoordMax, c_y: tcc_pkg::CoordMax});
    dir.push_back('{a_x: tcc_pkg::CoordMin, a_y: tcc_pkg::CoordMin,
                    b_x: tcc_pkg::CoordMax, b_y: tcc_pkg::CoordMin,
                    c_x: tcc_pkg::CoordMin, c_y: tcc_pkg::CoordMax});
    dir.push_back('{a_x: tcc_pkg::CoordMax, a_y: tcc_pkg::CoordMax,
                    b_x: tcc_pkg::CoordMax, b_y: tcc_pkg::CoordMin,
                    c_x: tcc_pkg::CoordMin, c_y: tcc_pkg::CoordMin});
    dir.push_back('{a_x: tcc_pkg::CoordMin, a_y: 0, b_x: tcc_pkg::CoordMax, b_y: 0,
                    c_x: 0, c_y: 1});
    dir.push_back('{a_x: tcc_pkg::CoordMin, a_y: 0, b_x: tcc_pkg::CoordMax, b_y: 1,
                    c_x: 0, c_y: 0});
    dir.push_back('{a_x: 0, a_y: 0, b_x: tcc_pkg::CoordMax, b_y: 1,
                    c_x: tcc_pkg::CoordMin, c_y: -1});
    dir.push_back('{a_x: -32'sh10000, a_y: -32'sh10000, b_x: 32'sh10000, b_y: 32'sh10000,
                    c_x: 32'sh10000, c_y: -32'sh10000});
    dir.push_back('{a_x: 1, a_y: 0, b_x: 0, b_y: 1, c_x: 0, c_y: 0});
    dir.push_back('{a_x: 3, a_y: 0, b_x: 0, b_y: 1, c_x: 0, c_y: 0});
    dir.push_back('{a_x: -1, a_y: -1, b_x: -1, b_y: 0, c_x: 0, c_y: -1});
    dir.push_back('{a_x: tcc_pkg::CoordMax, a_y: 0, b_x: 0, b_y: tcc_pkg::CoordMax,
                    c_x: 0, c_y: 0});
    dir.push_back('{a_x: tcc_pkg::CoordMin, a_y: 0, b_x: 0, b_y: tcc_pkg::CoordMin,
                    c_x: 0, c_y: 0});
    foreach (dir[i]) send_triangle(dir[i]);
  endtask

  initial begin
    tri_ch.valid      = 1'b0;
    tri_ch.vertex_a_x = '0;
    tri_ch.vertex_a_y = '0;
    tri_ch.vertex_b_x = '0;
    tri_ch.vertex_b_y = '0;
    tri_ch.vertex_c_x = '0;
    tri_ch.vertex_c_y = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // three phases of send idling and result stalling, the last with neither
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 34; recv_stall_pct = 57; end
        1: begin send_idle_pct = 57; recv_stall_pct = 34; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (RandomItems / 3) send_triangle(rand_triangle());
    end
    tri_ch.valid <= 1'b0;

    // drain
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
